### design/sbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    // Widths
    localparam int AMP_BITS_DEFAULT = 24;
    localparam int FS_BITS          = 24;
    localparam int CFG_DATA_BITS    = 24;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int LEVEL_CFG_BITS   = 17;
    localparam int LOG_BITS         = 21;   // 5 integer bits, 16 fraction bits
    localparam int FRAC_BITS        = 16;
    localparam int OUT_BITS         = 48;

    // Fixed-point constants
    localparam logic [18:0] DB_PER_OCT     = 19'd394566;   // 6.0206 dB per octave, Q16
    localparam logic [21:0] OCT_PER_DB     = 22'd2786635;  // 1 / 6.0206, Q24
    localparam logic [16:0] UNITY_RATIO    = 17'd65536;

    // Pipeline depths
    localparam int LOG_LAT    = 18;             // leading one, normalize, 16 squarings
    localparam int GAIN_STEPS = 16;
    localparam int CHAN_LAT   = LOG_LAT + 4 + GAIN_STEPS + 2;
    localparam int PIPE_DEPTH = CHAN_LAT + 2;

    // Register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FULL_SCALE         = 3'd0,
        CFG_MAIN_THRESHOLD     = 3'd1,
        CFG_SIDE_THRESHOLD     = 3'd2,
        CFG_MAIN_INVERSE_RATIO = 3'd3,
        CFG_SIDE_INVERSE_RATIO = 3'd4
    } cfg_index_t;

    // Per-channel compression settings
    typedef struct packed {
        logic signed [LEVEL_CFG_BITS-1:0] threshold;
        logic [LEVEL_CFG_BITS-1:0]        inverse_ratio;
    } chan_cfg_t;

    // Floor square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(-2^(i-16)) in Q30, used for fraction bit i of the gain exponent
    function automatic logic [29:0] root_const(input int i);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int k = 15; k >= i; k--)
        begin
            c = isqrt64(c << 30);
        end
        return c[29:0];
    endfunction

endpackage

`default_nettype wire

### design/sbc_log2.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined log2 in Q16: leading one, normalize, then one squaring per stage
module sbc_log2 #(
    parameter int W = sbc_pkg::FS_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [W-1:0]                 x,
    output logic      [sbc_pkg::LOG_BITS-1:0] log_q
);

    localparam int STEPS = sbc_pkg::FRAC_BITS;

    logic [4:0]  e_a;
    logic [31:0] x_a_reg;
    logic [4:0]  e_a_reg;

    logic [31:0]                   y_reg    [0:STEPS];
    logic [4:0]                    e_reg    [0:STEPS];
    logic [sbc_pkg::FRAC_BITS-1:0] frac_reg [0:STEPS];

    // Leading one
    always_comb
    begin
        e_a = '0;
        for (int i = 0; i < W; i++)
        begin
            if (x[i])
            begin
                e_a = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg <= 32'(x);
            e_a_reg <= e_a;
        end
    end

    // Normalize mantissa to Q31
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0]    <= x_a_reg << (5'd31 - e_a_reg);
            e_reg[0]    <= e_a_reg;
            frac_reg[0] <= '0;
        end
    end

    // One fraction bit per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] sh;

        assign sq = 64'(y_reg[k]) * 64'(y_reg[k]);
        assign sh = sq[63:31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e_reg[k+1] <= e_reg[k];
                if (sh[32])
                begin
                    y_reg[k+1]    <= sh[32:1];
                    frac_reg[k+1] <= frac_reg[k] | (16'd1 << (STEPS - 1 - k));
                end
                else
                begin
                    y_reg[k+1]    <= sh[31:0];
                    frac_reg[k+1] <= frac_reg[k];
                end
            end
        end
    end

    assign log_q = {e_reg[STEPS], frac_reg[STEPS]};

endmodule

`default_nettype wire

### design/sbc_chan.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel: level in dB, compression above the knee, back to linear
module sbc_chan #(
    parameter int W = sbc_pkg::AMP_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [W-1:0]                 mag,
    input  wire logic [sbc_pkg::LOG_BITS-1:0] log_fs,
    input  wire sbc_pkg::chan_cfg_t           cfg,
    output logic      [W-1:0]                 restored
);

    localparam int STEPS   = sbc_pkg::GAIN_STEPS;
    localparam int MAG_DLY = sbc_pkg::LOG_LAT + 4 + STEPS;

    logic [sbc_pkg::LOG_BITS-1:0] log_mag;
    logic [W-1:0]                 mag_dly_reg [0:MAG_DLY-1];

    sbc_log2 #(
        .W (W)
    ) u_log (
        .clk   (clk),
        .en    (en),
        .x     (mag),
        .log_q (log_mag)
    );

    // Magnitude follows along to the gain multiply
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_dly_reg[0] <= mag;
            for (int i = 1; i < MAG_DLY; i++)
            begin
                mag_dly_reg[i] <= mag_dly_reg[i-1];
            end
        end
    end

    // Log difference, split into sign and magnitude
    logic signed [21:0] diff;
    logic [20:0]        dabs_reg;
    logic               dneg_reg;

    assign diff = $signed({1'b0, log_mag}) - $signed({1'b0, log_fs});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dneg_reg <= diff[21];
            dabs_reg <= diff[21] ? 21'(-diff) : diff[20:0];
        end
    end

    // Octaves to 1/256 dB, round half away from zero
    logic [39:0]        db_sum;
    logic [15:0]        db_abs;
    logic signed [17:0] lvl_reg;

    assign db_sum = 40'(dabs_reg) * 40'(sbc_pkg::DB_PER_OCT) + 40'd8388608;
    assign db_abs = db_sum[39:24];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lvl_reg <= dneg_reg ? -$signed({2'b00, db_abs}) : $signed({2'b00, db_abs});
        end
    end

    // Attenuation above the knee
    logic signed [18:0] excess;
    logic [16:0]        ratio_sat;
    logic [16:0]        ratio_comp;
    logic [34:0]        att_sum;
    logic               over;
    logic [16:0]        att_reg;

    assign over       = lvl_reg > $signed({cfg.threshold[16], cfg.threshold});
    assign excess     = $signed({lvl_reg[17], lvl_reg})
                      - $signed({{2{cfg.threshold[16]}}, cfg.threshold});
    assign ratio_sat  = (cfg.inverse_ratio > sbc_pkg::UNITY_RATIO) ? sbc_pkg::UNITY_RATIO
                                                                   : cfg.inverse_ratio;
    assign ratio_comp = sbc_pkg::UNITY_RATIO - ratio_sat;
    assign att_sum    = 35'(excess[17:0]) * 35'(ratio_comp) + 35'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            att_reg <= over ? att_sum[32:16] : '0;
        end
    end

    // dB back to octaves, Q16
    logic [38:0] oct_sum;
    logic [22:0] a_reg [0:STEPS];

    assign oct_sum = 39'(att_reg) * 39'(sbc_pkg::OCT_PER_DB) + 39'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= oct_sum[38:16];
        end
    end

    // Fractional gain 2^-frac in Q30, one exponent bit per stage
    logic [30:0] g_reg [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_gain
        localparam logic [29:0] C = sbc_pkg::root_const(STEPS - 1 - k);
        logic [30:0] g_in;
        logic [60:0] g_mul;

        if (k == 0)
        begin : g_first
            assign g_in = 31'd1 << 30;
        end
        else
        begin : g_rest
            assign g_in = g_reg[k-1];
        end

        assign g_mul = 61'(g_in) * 61'(C);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k+1] <= a_reg[k];
                g_reg[k]   <= a_reg[k][STEPS-1-k] ? g_mul[60:30] : g_in;
            end
        end
    end

    // Magnitude times gain
    logic [W+30:0] prod_reg;
    logic [6:0]    n_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (W+31)'(mag_dly_reg[MAG_DLY-1]) * (W+31)'(g_reg[STEPS-1]);
            n_reg    <= a_reg[STEPS][22:16];
        end
    end

    // Integer octaves as a rounded right shift
    logic [63:0] shifted;
    logic [63:0] rounded;
    logic [W-1:0] restored_reg;

    assign shifted = 64'(prod_reg) >> (7'd29 + n_reg);
    assign rounded = shifted + 64'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            restored_reg <= (n_reg >= 7'd34) ? '0 : rounded[W:1];
        end
    end

    assign restored = restored_reg;

endmodule

`default_nettype wire

### design/spectral_bin_compress_product.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Most of the pipeline is the 16-step log2 squaring chain and the 16-step gain chain.
// Reset clears all valid bits and loads the register defaults (full scale
// 16777215, thresholds 0, inverse ratios 65536).
module spectral_bin_compress_product #(
    parameter int AMP_BITS = sbc_pkg::AMP_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [sbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [sbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [AMP_BITS-1:0]                 main_magnitude,
    input  wire logic [AMP_BITS-1:0]                 side_magnitude,
    input  wire logic                                last_bin,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [sbc_pkg::OUT_BITS-1:0]        combined_magnitude,
    output logic                                     last_bin_out
);

    localparam int DEPTH = sbc_pkg::PIPE_DEPTH;

    // Configuration registers
    logic [sbc_pkg::FS_BITS-1:0] full_scale_reg;
    sbc_pkg::chan_cfg_t          main_cfg_reg;
    sbc_pkg::chan_cfg_t          side_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg             <= '1;
            main_cfg_reg.threshold     <= '0;
            main_cfg_reg.inverse_ratio <= sbc_pkg::UNITY_RATIO;
            side_cfg_reg.threshold     <= '0;
            side_cfg_reg.inverse_ratio <= sbc_pkg::UNITY_RATIO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbc_pkg::CFG_FULL_SCALE:         full_scale_reg <= cfg_data;
                sbc_pkg::CFG_MAIN_THRESHOLD:     main_cfg_reg.threshold <= cfg_data[16:0];
                sbc_pkg::CFG_SIDE_THRESHOLD:     side_cfg_reg.threshold <= cfg_data[16:0];
                sbc_pkg::CFG_MAIN_INVERSE_RATIO: main_cfg_reg.inverse_ratio <= cfg_data[16:0];
                sbc_pkg::CFG_SIDE_INVERSE_RATIO: side_cfg_reg.inverse_ratio <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while the output item is not taken
    logic en;
    logic valid_reg [0:DEPTH-1];
    logic last_reg  [0:DEPTH-1];

    assign en       = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[0] <= last_bin;
            for (int i = 1; i < DEPTH; i++)
            begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    // Full-scale log, aligned with each item's magnitude logs
    logic [sbc_pkg::FS_BITS-1:0]  fs_eff;
    logic [sbc_pkg::LOG_BITS-1:0] log_fs;

    assign fs_eff = (full_scale_reg == '0) ? sbc_pkg::FS_BITS'(1) : full_scale_reg;

    sbc_log2 #(
        .W (sbc_pkg::FS_BITS)
    ) u_log_fs (
        .clk   (clk),
        .en    (en),
        .x     (fs_eff),
        .log_q (log_fs)
    );

    // Both channels
    logic [AMP_BITS-1:0] main_rest;
    logic [AMP_BITS-1:0] side_rest;

    sbc_chan #(
        .W (AMP_BITS)
    ) u_main (
        .clk      (clk),
        .en       (en),
        .mag      (main_magnitude),
        .log_fs   (log_fs),
        .cfg      (main_cfg_reg),
        .restored (main_rest)
    );

    sbc_chan #(
        .W (AMP_BITS)
    ) u_side (
        .clk      (clk),
        .en       (en),
        .mag      (side_magnitude),
        .log_fs   (log_fs),
        .cfg      (side_cfg_reg),
        .restored (side_rest)
    );

    // Product, then saturate to the output width
    logic [2*AMP_BITS-1:0]        prod_reg;
    logic [63:0]                  prod_ext;
    logic [sbc_pkg::OUT_BITS-1:0] out_reg;

    assign prod_ext = 64'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (2*AMP_BITS)'(main_rest) * (2*AMP_BITS)'(side_rest);
            out_reg  <= (|prod_ext[63:sbc_pkg::OUT_BITS]) ? '1
                                                          : prod_ext[sbc_pkg::OUT_BITS-1:0];
        end
    end

    assign out_valid          = valid_reg[DEPTH-1];
    assign combined_magnitude = out_reg;
    assign last_bin_out       = last_reg[DEPTH-1];

endmodule

`default_nettype wire

### tb/spectral_bin_compress_product_test.sv
`timescale 1ns / 1ps

module spectral_bin_compress_product_test;
    import sbc_pkg::*;

    localparam int AMP_W    = 24;
    localparam int DRAIN_CY = PIPE_DEPTH + 20;

    typedef struct packed {
        logic [AMP_W-1:0] main_mag;
        logic [AMP_W-1:0] side_mag;
        logic             last;
    } bin_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] product;
        logic                last;
    } product_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [AMP_W-1:0] main_magnitude;
    logic [AMP_W-1:0] side_magnitude;
    logic last_bin;
    logic out_valid;
    logic out_ready;
    logic [OUT_BITS-1:0] combined_magnitude;
    logic last_bin_out;

    spectral_bin_compress_product u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .main_magnitude     (main_magnitude),
        .side_magnitude     (side_magnitude),
        .last_bin           (last_bin),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .combined_magnitude (combined_magnitude),
        .last_bin_out       (last_bin_out)
    );

    // Shadow copy of the register file
    logic [23:0]        sh_full_scale;
    logic signed [16:0] sh_main_thr;
    logic signed [16:0] sh_side_thr;
    logic [16:0]        sh_main_ir;
    logic [16:0]        sh_side_ir;

    bin_t     pending_bins[$];
    product_t expected_products[$];
    int       mismatches;
    bit       no_idle;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q16 by repeated squaring, truncated
    function automatic longint log2_fix(input longint unsigned x);
        int e;
        longint unsigned y;
        longint f;
        e = 0;
        f = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        y = x << (31 - e);
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 31;
            if ((y >> 32) != 0)
            begin
                f = f | (longint'(1) << i);
                y = y >> 1;
            end
        end
        return (longint'(e) << 16) | f;
    endfunction

    // One channel: level, knee compression, gain back to linear
    function automatic longint unsigned compress_mag(input longint unsigned mag,
                                                     input longint unsigned fs,
                                                     input longint thr,
                                                     input longint unsigned r);
        longint d;
        longint lvl;
        longint unsigned mabs;
        longint unsigned rnd;
        longint unsigned att;
        longint unsigned a;
        longint unsigned n;
        longint unsigned g;
        longint unsigned c;
        if (mag == 0)
            return 0;
        if (r > 65536)
            r = 65536;
        d = log2_fix(mag) - log2_fix(fs);
        mabs = (d < 0) ? unsigned'(-d) : unsigned'(d);
        rnd = (mabs * 394566 + (64'd1 << 23)) >> 24;
        lvl = (d < 0) ? -longint'(rnd) : longint'(rnd);
        att = 0;
        if (lvl > thr)
            att = (unsigned'(lvl - thr) * (65536 - r) + 32768) >> 16;
        a = (att * 2786635 + 32768) >> 16;
        n = a >> 16;
        g = 64'd1 << 30;
        c = 64'd1 << 29;
        for (int i = 15; i >= 0; i--)
        begin
            c = floor_sqrt(c << 30);
            if (((a >> i) & 1) != 0)
                g = (g * c) >> 30;
        end
        if (30 + n >= 64)
            return 0;
        return (mag * g + (64'd1 << (29 + n))) >> (30 + n);
    endfunction

    function automatic product_t predict_product(input bin_t b);
        product_t p;
        longint unsigned fs;
        longint unsigned m;
        longint unsigned s;
        longint unsigned prod;
        fs = (sh_full_scale == 0) ? 1 : sh_full_scale;
        m = compress_mag(b.main_mag, fs, longint'(sh_main_thr), sh_main_ir);
        s = compress_mag(b.side_mag, fs, longint'(sh_side_thr), sh_side_ir);
        prod = m * s;
        if (prod > 64'hFFFF_FFFF_FFFF)
            prod = 64'hFFFF_FFFF_FFFF;
        p.product = prod[OUT_BITS-1:0];
        p.last = b.last;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: sends pending bins with random gaps
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        bin_t b;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            main_magnitude <= '0;
            side_magnitude <= '0;
            last_bin <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                b.main_mag = main_magnitude;
                b.side_mag = side_magnitude;
                b.last = last_bin;
                expected_products.push_back(predict_product(b));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bins.size() > 0)
                begin
                    b = pending_bins.pop_front();
                    main_magnitude <= b.main_mag;
                    side_magnitude <= b.side_mag;
                    last_bin <= b.last;
                    in_valid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 18);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results, stalls the output at random
    int recv_stall;
    always @(posedge clk or negedge rst_n)
    begin
        product_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    report_mismatch("unexpected item", combined_magnitude, 0);
                end
                else
                begin
                    e = expected_products.pop_front();
                    if (combined_magnitude !== e.product)
                        report_mismatch("combined_magnitude", combined_magnitude, e.product);
                    if (last_bin_out !== e.last)
                        report_mismatch("last_bin_out", last_bin_out, e.last);
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FULL_SCALE:         sh_full_scale = val;
            CFG_MAIN_THRESHOLD:     sh_main_thr = val[16:0];
            CFG_SIDE_THRESHOLD:     sh_side_thr = val[16:0];
            CFG_MAIN_INVERSE_RATIO: sh_main_ir = val[16:0];
            CFG_SIDE_INVERSE_RATIO: sh_side_ir = val[16:0];
            default: ;
        endcase
    endtask

    // Wait for the pipe to empty, then let it settle
    task automatic wait_drained();
        while (pending_bins.size() > 0 || in_valid || expected_products.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_mag();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0)
            return 24'($urandom_range(0, 3));
        if (k <= 2)
            return 24'($urandom) & 24'((64'd1 << $urandom_range(1, 24)) - 1);
        return 24'($urandom);
    endfunction

    function automatic logic [16:0] rand_thr();
        case ($urandom_range(0, 5))
            0: return 17'(-40960);
            1: return 17'd12288;
            2: return 17'h10000;
            3: return 17'h0FFFF;
            default: return 17'($urandom_range(0, 53248) - 40960);
        endcase
    endfunction

    function automatic logic [16:0] rand_ratio();
        case ($urandom_range(0, 6))
            0: return 17'd0;
            1: return 17'd1;
            2: return UNITY_RATIO;
            3: return 17'h1FFFF;
            default: return 17'($urandom_range(1, 65536));
        endcase
    endfunction

    function automatic logic [23:0] rand_fs();
        case ($urandom_range(0, 4))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_bin(input logic [23:0] m, input logic [23:0] s, input logic l);
        bin_t b;
        b.main_mag = m;
        b.side_mag = s;
        b.last = l;
        pending_bins.push_back(b);
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        no_idle = 1'b0;
        sh_full_scale = 24'hFFFFFF;
        sh_main_thr = '0;
        sh_side_thr = '0;
        sh_main_ir = UNITY_RATIO;
        sh_side_ir = UNITY_RATIO;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, no compression, extremes and zeros
        queue_bin(24'd0, 24'd0, 1'b0);
        queue_bin(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        queue_bin(24'd1, 24'hFFFFFF, 1'b0);
        queue_bin(24'd0, 24'hFFFFFF, 1'b1);
        queue_bin(24'hFFFFFF, 24'd0, 1'b0);
        queue_bin(24'h800000, 24'h7FFFFF, 1'b1);
        wait_drained();

        // Directed: hard compression, tiny full scale, infinite ratio
        write_reg(CFG_FULL_SCALE, 24'd1);
        write_reg(CFG_MAIN_THRESHOLD, 24'(17'(-40960)));
        write_reg(CFG_SIDE_THRESHOLD, 24'd12288);
        write_reg(CFG_MAIN_INVERSE_RATIO, 24'd0);
        write_reg(CFG_SIDE_INVERSE_RATIO, 24'd1);
        queue_bin(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        queue_bin(24'd1, 24'd1, 1'b1);
        queue_bin(24'd2, 24'h000FFF, 1'b0);
        queue_bin(24'h123456, 24'd0, 1'b1);
        wait_drained();

        // Directed: full scale zero, ratio above unity, lowest threshold
        write_reg(CFG_FULL_SCALE, 24'd0);
        write_reg(CFG_MAIN_THRESHOLD, 24'h10000);
        write_reg(CFG_SIDE_THRESHOLD, 24'h0FFFF);
        write_reg(CFG_MAIN_INVERSE_RATIO, 24'h1FFFF);
        write_reg(CFG_SIDE_INVERSE_RATIO, 24'd65535);
        queue_bin(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        queue_bin(24'd1, 24'hABCDEF, 1'b0);
        queue_bin(24'h555555, 24'hAAAAAA, 1'b1);
        queue_bin(24'd0, 24'd7, 1'b0);
        wait_drained();

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_FULL_SCALE, rand_fs());
            write_reg(CFG_MAIN_THRESHOLD, 24'(rand_thr()));
            write_reg(CFG_SIDE_THRESHOLD, 24'(rand_thr()));
            write_reg(CFG_MAIN_INVERSE_RATIO, 24'(rand_ratio()));
            write_reg(CFG_SIDE_INVERSE_RATIO, 24'(rand_ratio()));
            no_idle = (ph % 4 == 3);
            for (int i = 0; i < 190; i++)
                queue_bin(rand_mag(), rand_mag(), 1'($urandom));
            wait_drained();
        end

        if (mismatches == 0)
            $display("PASS spectral_bin_compress_product");
        else
            $display("FAIL spectral_bin_compress_product");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("FAIL spectral_bin_compress_product");
        $finish;
    end

endmodule

### files.f
design/sbc_pkg.sv
design/sbc_log2.sv
design/sbc_chan.sv
design/spectral_bin_compress_product.sv
tb/spectral_bin_compress_product_test.sv
